[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define OHM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also live during reset
`define OHM_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ohm_pkg.sv]
// ----------------------------------------------------------------------------
// ohm_pkg
// Types, widths and constants of the old-to-new reference hash map.
// ----------------------------------------------------------------------------
package ohm_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int REF_WIDTH = 64;

	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int NEED_W = CNT_W + 2;

	localparam int CMD_W     = 3;
	localparam int FIELD_W   = 64;
	localparam int STATUS_W  = 3;
	localparam int CFG_W     = 11;
	localparam int S_TDATA_W = ((CMD_W + 2 * FIELD_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((FIELD_W + STATUS_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] SLOT_CNT_RST = 11'd1024;

	localparam int HASH_IN_W = 31;
	localparam int HASH_W    = 32;
	localparam logic [15:0] MLCG_A = 16'd48271;
	localparam logic [32:0] MLCG_M = 33'h0_7FFF_FFFF;
	localparam int MOD_BITS  = 4;
	localparam int MOD_ITERS = HASH_W / MOD_BITS;
	localparam int MOD_CNT_W = $clog2(MOD_ITERS);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT     = 3'd0,
		CMD_LOOKUP     = 3'd1,
		CMD_ITER_FIRST = 3'd2,
		CMD_ITER_NEXT  = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 3'd0,
		ST_SKIP = 3'd1,
		ST_DUP  = 3'd2,
		ST_FULL = 3'd3,
		ST_NONE = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_DECODE,
		S_HASH,
		S_PROBE_RD,
		S_PROBE_CMP,
		S_ITER_RD,
		S_ITER_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [HASH_IN_W-1:0] key;
		logic [CNT_W-1:0]     n;
	} hash_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] home;
	} hash_rsp_t;

endpackage

[hdl/old_new_hash_map.sv]
// ----------------------------------------------------------------------------
// old_new_hash_map
// Fixed-size open-addressing map of old to new references, linear probing.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (command, old_ref, new_ref) and each gives
// exactly one response on the m_ channel (ref_out, status). One request is in
// work at a time; s_tready is high only while the block is idle, and it stays
// high while a finished response still waits in the output register.
// Insert and lookup: the request is decoded, then the home slot comes from a
// registered pair of 16x15 and 16x16 multiplies, a reduction and a remainder
// unit at 4 bits per cycle; each probed slot of the key memory is then read
// and compared, and the response is posted. Checks that need no table access
// answer straight from decode. Iteration steps read and compare one slot at a
// time, since each slot is a memory read.
// Clear runs a sweep that zeroes the key of every one of the MAX_SLOTS (1024)
// slots, then responds. Reset starts the same sweep; no request is taken during
// it, while slot_count writes are taken at any time.
// A stalled receiver holds the response in the output register; the next
// request is taken but its response waits until that register drains.
// ----------------------------------------------------------------------------
module old_new_hash_map (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// command[2:0], old_ref[66:3], new_ref[130:67], zero fill above
	input  logic [ohm_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// ref_out[63:0], status[66:64], zero fill above
	output logic [ohm_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                            cfg_wr_en,
	input  logic [ohm_pkg::CFG_W-1:0]       cfg_wr_data
);

	localparam int SW  = ohm_pkg::SLOT_W;
	localparam int CW  = ohm_pkg::CNT_W;
	localparam int NW  = ohm_pkg::NEED_W;
	localparam int RW  = ohm_pkg::REF_WIDTH;
	localparam int FW  = ohm_pkg::FIELD_W;
	localparam int KW  = ohm_pkg::CMD_W;
	localparam int MW  = ohm_pkg::M_TDATA_W;

	ohm_pkg::state_t    state_q, state_d;
	ohm_pkg::status_t   res_st_q, res_st_d;
	ohm_pkg::hash_req_t hash_req;
	ohm_pkg::hash_rsp_t hash_rsp;

	logic [ohm_pkg::CFG_W-1:0] slot_cnt_q;
	logic [CW-1:0]  eff_n;
	logic [KW-1:0]  cmd_q;
	logic [RW-1:0]  old_q;
	logic [RW-1:0]  new_q;
	logic [SW-1:0]  probe_q, probe_d;
	logic [SW-1:0]  home_q, home_d;
	logic [SW-1:0]  probe_nx;
	logic [CW-1:0]  cursor_q, cursor_d;
	logic           iter_act_q, iter_act_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [CW-1:0]  div3_q, div3_d;
	logic [1:0]     mod3_q, mod3_d;
	logic [SW-1:0]  sweep_q, sweep_d;
	logic           sweep_resp_q, sweep_resp_d;
	logic [RW-1:0]  res_ref_q, res_ref_d;
	logic [NW-1:0]  need;
	logic           out_free;
	logic           accept;

	logic           key_we;
	logic [SW-1:0]  key_waddr;
	logic [RW-1:0]  key_wdata;
	logic           val_we;
	logic           rd_en;
	logic [SW-1:0]  rd_addr;
	logic [RW-1:0]  key_rd;
	logic [RW-1:0]  val_rd;

	logic           m_tvalid_q;
	logic [MW-1:0]  m_tdata_q;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ohm_pkg::S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		if (slot_cnt_q == '0) begin
			eff_n = CW'(1);
		end else if (32'(slot_cnt_q) > 32'(ohm_pkg::MAX_SLOTS)) begin
			eff_n = CW'(ohm_pkg::MAX_SLOTS);
		end else begin
			eff_n = CW'(slot_cnt_q);
		end
	end

	assign need     = NW'(cnt_q) + NW'(div3_q) + NW'(2);
	assign probe_nx = ((CW'(probe_q) + CW'(1)) == eff_n) ? '0 : probe_q + SW'(1);

	ohm_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hash_req),
		.rsp    (hash_rsp)
	);

	ohm_ram #(
		.DEPTH (ohm_pkg::MAX_SLOTS),
		.WIDTH (RW)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_rd)
	);

	ohm_ram #(
		.DEPTH (ohm_pkg::MAX_SLOTS),
		.WIDTH (RW)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (probe_q),
		.wdata (new_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ohm_pkg::S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		res_st_d       = res_st_q;
		res_ref_d      = res_ref_q;
		probe_d        = probe_q;
		home_d         = home_q;
		cursor_d       = cursor_q;
		iter_act_d     = iter_act_q;
		cnt_d          = cnt_q;
		div3_d         = div3_q;
		mod3_d         = mod3_q;
		sweep_d        = sweep_q;
		sweep_resp_d   = sweep_resp_q;
		key_we         = 1'b0;
		key_waddr      = probe_q;
		key_wdata      = old_q;
		val_we         = 1'b0;
		rd_en          = 1'b0;
		rd_addr        = probe_q;
		hash_req.start = 1'b0;
		hash_req.key   = old_q[ohm_pkg::HASH_IN_W-1:0];
		hash_req.n     = eff_n;
		unique case (state_q)
			ohm_pkg::S_SWEEP: begin
				key_we    = 1'b1;
				key_waddr = sweep_q;
				key_wdata = '0;
				sweep_d   = sweep_q + SW'(1);
				if (sweep_q == SW'(ohm_pkg::MAX_SLOTS - 1)) begin
					sweep_d      = '0;
					sweep_resp_d = 1'b0;
					state_d      = sweep_resp_q ? ohm_pkg::S_DONE : ohm_pkg::S_IDLE;
				end
			end
			ohm_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = ohm_pkg::S_DECODE;
				end
			end
			ohm_pkg::S_DECODE: begin
				res_ref_d = '0;
				res_st_d  = ohm_pkg::ST_OK;
				state_d   = ohm_pkg::S_DONE;
				unique case (cmd_q)
					ohm_pkg::CMD_INSERT: begin
						if (need > NW'(eff_n)) begin
							res_st_d = ohm_pkg::ST_FULL;
						end else if (old_q == '0 || old_q == new_q) begin
							res_st_d = ohm_pkg::ST_SKIP;
						end else begin
							hash_req.start = 1'b1;
							state_d        = ohm_pkg::S_HASH;
						end
					end
					ohm_pkg::CMD_LOOKUP: begin
						if (old_q == '0) begin
							res_st_d = ohm_pkg::ST_NONE;
						end else begin
							hash_req.start = 1'b1;
							state_d        = ohm_pkg::S_HASH;
						end
					end
					ohm_pkg::CMD_ITER_FIRST: begin
						if (cnt_q == '0) begin
							res_st_d = ohm_pkg::ST_NONE;
						end else begin
							iter_act_d = 1'b1;
							cursor_d   = '0;
							state_d    = ohm_pkg::S_ITER_RD;
						end
					end
					ohm_pkg::CMD_ITER_NEXT: begin
						if (!iter_act_q) begin
							res_st_d = ohm_pkg::ST_NONE;
						end else begin
							state_d = ohm_pkg::S_ITER_RD;
						end
					end
					ohm_pkg::CMD_CLEAR: begin
						cnt_d        = '0;
						div3_d       = '0;
						mod3_d       = 2'd1;
						iter_act_d   = 1'b0;
						cursor_d     = '0;
						sweep_resp_d = 1'b1;
						state_d      = ohm_pkg::S_SWEEP;
					end
					default: begin
						state_d = ohm_pkg::S_DONE;
					end
				endcase
			end
			ohm_pkg::S_HASH: begin
				if (hash_rsp.done) begin
					probe_d = hash_rsp.home;
					home_d  = hash_rsp.home;
					state_d = ohm_pkg::S_PROBE_RD;
				end
			end
			ohm_pkg::S_PROBE_RD: begin
				rd_en   = 1'b1;
				rd_addr = probe_q;
				state_d = ohm_pkg::S_PROBE_CMP;
			end
			ohm_pkg::S_PROBE_CMP: begin
				if (key_rd == old_q || key_rd == '0) begin
					state_d = ohm_pkg::S_DONE;
					if (cmd_q == ohm_pkg::CMD_INSERT) begin
						if (key_rd == old_q) begin
							res_st_d = ohm_pkg::ST_DUP;
						end else begin
							key_we = 1'b1;
							val_we = 1'b1;
							cnt_d  = cnt_q + CW'(1);
							if (mod3_q == 2'd2) begin
								mod3_d = 2'd0;
								div3_d = div3_q + CW'(1);
							end else begin
								mod3_d = mod3_q + 2'd1;
							end
						end
					end else if (key_rd == '0) begin
						res_st_d = ohm_pkg::ST_NONE;
					end else begin
						res_ref_d = val_rd;
					end
				end else if (probe_nx == home_q) begin
					state_d  = ohm_pkg::S_DONE;
					res_st_d = (cmd_q == ohm_pkg::CMD_INSERT) ? ohm_pkg::ST_FULL
					                                          : ohm_pkg::ST_NONE;
				end else begin
					probe_d = probe_nx;
					state_d = ohm_pkg::S_PROBE_RD;
				end
			end
			ohm_pkg::S_ITER_RD: begin
				if (cursor_q >= eff_n) begin
					iter_act_d = 1'b0;
					cursor_d   = '0;
					res_st_d   = ohm_pkg::ST_NONE;
					state_d    = ohm_pkg::S_DONE;
				end else begin
					rd_en    = 1'b1;
					rd_addr  = cursor_q[SW-1:0];
					cursor_d = cursor_q + CW'(1);
					state_d  = ohm_pkg::S_ITER_CMP;
				end
			end
			ohm_pkg::S_ITER_CMP: begin
				if (key_rd != '0) begin
					res_ref_d = key_rd;
					res_st_d  = ohm_pkg::ST_OK;
					state_d   = ohm_pkg::S_DONE;
				end else begin
					state_d = ohm_pkg::S_ITER_RD;
				end
			end
			ohm_pkg::S_DONE: begin
				if (out_free) begin
					state_d = ohm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ohm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cnt_q   <= ohm_pkg::SLOT_CNT_RST;
			cursor_q     <= '0;
			iter_act_q   <= 1'b0;
			cnt_q        <= '0;
			div3_q       <= '0;
			mod3_q       <= 2'd1;
			sweep_q      <= '0;
			sweep_resp_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				slot_cnt_q <= cfg_wr_data;
			end
			cursor_q     <= cursor_d;
			iter_act_q   <= iter_act_d;
			cnt_q        <= cnt_d;
			div3_q       <= div3_d;
			mod3_q       <= mod3_d;
			sweep_q      <= sweep_d;
			sweep_resp_q <= sweep_resp_d;
			if (state_q == ohm_pkg::S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tdata[KW-1:0];
			old_q <= s_tdata[KW + RW - 1:KW];
			new_q <= s_tdata[KW + FW + RW - 1:KW + FW];
		end
		res_st_q  <= res_st_d;
		res_ref_q <= res_ref_d;
		probe_q   <= probe_d;
		home_q    <= home_d;
		if (state_q == ohm_pkg::S_DONE && out_free) begin
			m_tdata_q <= MW'({res_st_q, FW'(res_ref_q)});
		end
	end

endmodule

[hdl/ohm_ram.sv]
// ----------------------------------------------------------------------------
// ohm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ohm_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/ohm_hash.sv]
// ----------------------------------------------------------------------------
// ohm_hash
// Home slot unit: one MLCG step on the key, then an iterative remainder
// by the slot count, a few quotient bits per cycle.
// ----------------------------------------------------------------------------
module ohm_hash (
	input  logic               clk,
	input  logic               arst_n,
	input  ohm_pkg::hash_req_t req,
	output ohm_pkg::hash_rsp_t rsp
);

	localparam int CW = ohm_pkg::CNT_W;
	localparam int HW = ohm_pkg::HASH_W;
	localparam int MB = ohm_pkg::MOD_BITS;
	localparam int MCW = ohm_pkg::MOD_CNT_W;

	logic [30:0]      lo_d;
	logic [31:0]      hi_d;
	logic [30:0]      lo_s1;
	logic [31:0]      hi_s1;
	logic             vld_s1;
	logic [CW-1:0]    n_s1;
	logic [32:0]      sum;
	logic [32:0]      red;
	logic [HW-1:0]    div_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    n_q;
	logic [MCW-1:0]   cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [HW-1:0]    div_nx;
	logic [CW-1:0]    rem_nx;
	logic [CW:0]      trial;

	assign lo_d = 31'(ohm_pkg::MLCG_A) * 31'(req.key[14:0]);
	assign hi_d = 32'(ohm_pkg::MLCG_A) * 32'(req.key[30:15]);

	assign sum = 33'(lo_s1) + 33'({hi_s1[15:0], 15'd0}) + 33'(hi_s1[31:16]);
	assign red = (sum > ohm_pkg::MLCG_M) ? sum - ohm_pkg::MLCG_M : sum;

	always_comb begin
		div_nx = div_q;
		rem_nx = rem_q;
		for (int b = 0; b < MB; b++) begin
			trial = {rem_nx, div_nx[HW-1]};
			div_nx = {div_nx[HW-2:0], 1'b0};
			if (trial >= {1'b0, n_q}) begin
				trial = trial - {1'b0, n_q};
			end
			rem_nx = trial[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			vld_s1 <= req.start;
			done_q <= 1'b0;
			if (vld_s1) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + MCW'(1);
				if (cnt_q == MCW'(ohm_pkg::MOD_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			lo_s1 <= lo_d;
			hi_s1 <= hi_d;
			n_s1  <= req.n;
		end
		if (vld_s1) begin
			div_q <= red[HW-1:0];
			rem_q <= '0;
			n_q   <= n_s1;
		end else if (busy_q) begin
			div_q <= div_nx;
			rem_q <= rem_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.home = rem_q[ohm_pkg::SLOT_W-1:0];

endmodule

[hdl/ohm_checker.sv]
// ----------------------------------------------------------------------------
// ohm_checker
// Port-level checks on the hash map, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ohm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ohm_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int FW = ohm_pkg::FIELD_W;
	localparam int SW = ohm_pkg::STATUS_W;
	localparam int MW = ohm_pkg::M_TDATA_W;

	logic [SW-1:0] st;
	logic [FW-1:0] ref_out;

	assign st      = m_tdata[FW + SW - 1:FW];
	assign ref_out = m_tdata[FW-1:0];

	`OHM_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "response changed while stalled")
	`OHM_ASSERT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "request taken while busy")
	`OHM_ASSERT(a_status_range, clk, arst_n, m_tvalid |-> st <= SW'(ohm_pkg::ST_NONE), "status code out of range")
	`OHM_ASSERT(a_ref_zero, clk, arst_n, m_tvalid && st != SW'(ohm_pkg::ST_OK) |-> ref_out == '0, "reference not zero on a failed request")
	`OHM_ASSERT(a_fill_zero, clk, arst_n, m_tvalid |-> m_tdata[MW-1:FW + SW] == '0, "fill bits not zero")

endmodule

bind old_new_hash_map ohm_checker u_ohm_checker (.*);

[tb/old_new_hash_map_checker.sv]
// ----------------------------------------------------------------------------
// old_new_hash_map_checker
// Watches the request, response and slot_count channels of the reference map.
// Keeps its own copy of the key table, the stored values, the entry count and
// the walk cursor. Works out the reply to every accepted request and compares
// each accepted response, in order, with the oldest reply still outstanding.
// ----------------------------------------------------------------------------
module old_new_hash_map_checker
	import ohm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_wr_en,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	output int                   mismatches,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] PM_MULT = 64'd48271;
	localparam logic [63:0] PM_MOD  = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] LOW31   = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] LOW15   = 64'h0000_0000_0000_7FFF;
	localparam logic [63:0] LOW16   = 64'h0000_0000_0000_FFFF;

	typedef struct {
		logic [FIELD_W-1:0] ref_out;
		status_t            status;
	} map_reply_t;

	logic [FIELD_W-1:0] key_store [MAX_SLOTS];
	logic [FIELD_W-1:0] value_store [MAX_SLOTS];
	int unsigned        live_entries;
	int unsigned        walk_pos;
	bit                 walk_on;
	logic [CFG_W-1:0]   slot_reg;
	map_reply_t         replies_due [$];
	int                 fail_tally;

	map_reply_t         want;
	logic [CMD_W-1:0]   req_cmd;
	logic [FIELD_W-1:0] req_old;
	logic [FIELD_W-1:0] req_new;
	logic [FIELD_W-1:0] got_ref;
	logic [STATUS_W-1:0] got_status;

	function automatic int unsigned effective_slots();
		int unsigned n;
		n = slot_reg;
		if (n == 0)
			n = 1;
		if (n > MAX_SLOTS)
			n = MAX_SLOTS;
		return n;
	endfunction

	function automatic int unsigned home_slot(logic [FIELD_W-1:0] key);
		logic [63:0] seed;
		logic [63:0] lo;
		logic [63:0] hi;
		seed = key & LOW31;
		lo = PM_MULT * (seed & LOW15);
		hi = PM_MULT * (seed >> 15);
		seed = lo + ((hi & LOW16) << 15) + (hi >> 16);
		if (seed > PM_MOD)
			seed -= PM_MOD;
		return seed % effective_slots();
	endfunction

	// slot holding key or first empty slot on its path, -1 when none
	function automatic int probe_slot(logic [FIELD_W-1:0] key);
		int unsigned n;
		int unsigned home;
		int unsigned idx;
		n = effective_slots();
		home = home_slot(key);
		idx = home;
		do begin
			if (key_store[idx] == key || key_store[idx] == '0)
				return idx;
			idx++;
			if (idx >= n)
				idx = 0;
		end while (idx != home);
		return -1;
	endfunction

	function automatic map_reply_t walk_step();
		map_reply_t r;
		int unsigned n;
		logic [FIELD_W-1:0] k;
		r.ref_out = '0;
		r.status = ST_NONE;
		n = effective_slots();
		if (!walk_on)
			return r;
		while (walk_pos < n) begin
			k = key_store[walk_pos];
			walk_pos++;
			if (k != '0) begin
				r.ref_out = k;
				r.status = ST_OK;
				return r;
			end
		end
		walk_on = 1'b0;
		walk_pos = 0;
		return r;
	endfunction

	function automatic map_reply_t predict_reply(logic [CMD_W-1:0] cmd,
			logic [FIELD_W-1:0] old_key, logic [FIELD_W-1:0] new_ref);
		map_reply_t r;
		int unsigned need;
		int slot;
		r.ref_out = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_INSERT: begin
				need = (live_entries + 1) + (live_entries + 1) / 3 + 1;
				if (need > effective_slots()) begin
					r.status = ST_FULL;
				end else if (old_key == '0 || old_key == new_ref) begin
					r.status = ST_SKIP;
				end else begin
					slot = probe_slot(old_key);
					if (slot < 0) begin
						r.status = ST_FULL;
					end else if (key_store[slot] == old_key) begin
						r.status = ST_DUP;
					end else begin
						key_store[slot] = old_key;
						value_store[slot] = new_ref;
						live_entries++;
					end
				end
			end
			CMD_LOOKUP: begin
				slot = (old_key == '0) ? -1 : probe_slot(old_key);
				if (slot < 0 || key_store[slot] == '0)
					r.status = ST_NONE;
				else
					r.ref_out = value_store[slot];
			end
			CMD_ITER_FIRST: begin
				if (live_entries == 0) begin
					r.status = ST_NONE;
				end else begin
					walk_on = 1'b1;
					walk_pos = 0;
					r = walk_step();
				end
			end
			CMD_ITER_NEXT: begin
				r = walk_step();
			end
			CMD_CLEAR: begin
				foreach (key_store[i])
					key_store[i] = '0;
				live_entries = 0;
				walk_pos = 0;
				walk_on = 1'b0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (key_store[i]) begin
				key_store[i] = '0;
				value_store[i] = '0;
			end
			live_entries = 0;
			walk_pos = 0;
			walk_on = 1'b0;
			slot_reg = SLOT_CNT_RST;
			replies_due.delete();
			fail_tally = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				slot_reg = cfg_wr_data;
			if (m_tvalid && m_tready) begin
				got_ref = m_tdata[FIELD_W-1:0];
				got_status = m_tdata[FIELD_W +: STATUS_W];
				if (replies_due.size() == 0) begin
					$error("response with no request outstanding: ref_out %h status %0d",
						got_ref, got_status);
					fail_tally++;
				end else begin
					want = replies_due.pop_front();
					if (got_ref !== want.ref_out) begin
						$error("ref_out mismatch: expected %h, got %h", want.ref_out, got_ref);
						fail_tally++;
					end
					if (got_status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status,
							got_status);
						fail_tally++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				req_cmd = s_tdata[CMD_W-1:0];
				req_old = s_tdata[CMD_W +: FIELD_W];
				req_new = s_tdata[CMD_W+FIELD_W +: FIELD_W];
				replies_due.push_back(predict_reply(req_cmd, req_old, req_new));
			end
			pending <= replies_due.size();
			mismatches <= fail_tally;
		end
	end

endmodule

[tb/old_new_hash_map_tb.sv]
// ----------------------------------------------------------------------------
// old_new_hash_map_tb
// Drives request streams into the reference map under several slot counts,
// from a short directed run over the corner cases into long random mixes of
// inserts, lookups, table walks and clears. The checker beside the block
// predicts and compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module old_new_hash_map_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ohm_pkg::*;

	localparam int     CLK_HALF    = 10;
	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam int     TAIL_CYCLES = 200;
	localparam int     POOL_CAP    = 48;
	localparam int     BIG_QUOTA   = 100;
	localparam int     SMALL_QUOTA = 145;
	localparam int     WALK_CAP    = 70;

	localparam logic [CMD_W-1:0]   CMD_RSVD_FIRST = 3'd5;
	localparam logic [CMD_W-1:0]   CMD_RSVD_LAST  = 3'd7;
	localparam logic [FIELD_W-1:0] ALL_ONES       = '1;
	localparam logic [FIELD_W-1:0] TOP_BIT        = 64'h8000_0000_0000_0000;
	localparam logic [FIELD_W-1:0] HASH_IN_MAX    = 64'h0000_0000_7FFF_FFFF;
	localparam logic [FIELD_W-1:0] HASH_IN_ZERO   = 64'h0000_0000_8000_0000;
	localparam logic [FIELD_W-1:0] HASH_IN_ALIAS  = 64'h0000_0001_7FFF_FFFF;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]     cfg_wr_data = '0;

	int                   mismatches;
	int                   pending;
	longint               cycle_count = 0;
	int                   burst_left = 0;
	int unsigned          slots_now = SLOT_CNT_RST;
	logic [FIELD_W-1:0]   key_pool [$];
	rx_mode_t             ready_mode = RX_OPEN;
	int                   mode_left = 0;
	int                   ready_phase = 0;
	int unsigned          phase_slots [14] =
		'{16, 1, 64, 8, 2, 0, 1024, 5, 2047, 3, 40, 12, 256, 24};

	old_new_hash_map dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	old_new_hash_map_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= rx_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(64, 256);
		end else begin
			mode_left <= mode_left - 1;
		end
		ready_phase <= (ready_phase == 4) ? 0 : ready_phase + 1;
		case (ready_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 7) != 0);
			default:   m_tready <= (ready_phase >= 2);
		endcase
	end

	task automatic send_request(input logic [CMD_W-1:0] cmd,
			input logic [FIELD_W-1:0] old_key, input logic [FIELD_W-1:0] new_ref);
		logic [S_TDATA_W-1:0] word;
		word = '0;
		word[CMD_W-1:0] = cmd;
		word[CMD_W +: FIELD_W] = old_key;
		word[CMD_W+FIELD_W +: FIELD_W] = new_ref;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	// hold requests until every reply is back, then retune the table size
	task automatic hold_and_set_slots(input logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		slots_now = (value == 0) ? 1 : ((value > MAX_SLOTS) ? MAX_SLOTS : value);
		burst_left = 0;
	endtask

	function automatic logic [FIELD_W-1:0] pick_key();
		logic [FIELD_W-1:0] k;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			k = {$urandom, $urandom};
		end else if (roll < 55) begin
			k = $urandom_range(1, 4 * slots_now);
		end else if (roll < 70 && key_pool.size() > 0) begin
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			k[FIELD_W-1:31] = 33'({$urandom, $urandom});
		end else if (roll < 80 && key_pool.size() > 0) begin
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		end else begin
			case ($urandom_range(0, 3))
				0:       k = ALL_ONES;
				1:       k = TOP_BIT;
				2:       k = HASH_IN_MAX;
				default: k = HASH_IN_ZERO;
			endcase
		end
		if (k != '0) begin
			if (key_pool.size() >= POOL_CAP)
				key_pool.delete($urandom_range(0, key_pool.size() - 1));
			key_pool.push_back(k);
		end
		return k;
	endfunction

	task automatic run_mix(input int quota);
		int unsigned roll;
		int unsigned steps;
		logic [FIELD_W-1:0] old_key;
		logic [FIELD_W-1:0] new_ref;
		while (quota > 0) begin
			roll = $urandom_range(0, 99);
			if (roll < 42) begin
				old_key = pick_key();
				new_ref = {$urandom, $urandom};
				case ($urandom_range(0, 19))
					0:       new_ref = old_key;
					1:       new_ref = '0;
					2:       old_key = '0;
					default: begin
					end
				endcase
				send_request(CMD_INSERT, old_key, new_ref);
				quota--;
			end else if (roll < 72) begin
				if ($urandom_range(0, 3) != 0 && key_pool.size() > 0)
					old_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				else
					old_key = pick_key();
				if ($urandom_range(0, 24) == 0)
					old_key = '0;
				send_request(CMD_LOOKUP, old_key, {$urandom, $urandom});
				quota--;
			end else if (roll < 88) begin
				if ($urandom_range(0, 3) == 0)
					steps = (slots_now + 1 < WALK_CAP) ? slots_now + 1 : WALK_CAP;
				else
					steps = $urandom_range(0, 12);
				send_request(CMD_ITER_FIRST, {$urandom, $urandom}, {$urandom, $urandom});
				quota--;
				repeat (steps) begin
					send_request(CMD_ITER_NEXT, {$urandom, $urandom}, {$urandom, $urandom});
					quota--;
				end
			end else if (roll < 95) begin
				send_request(CMD_ITER_NEXT, {$urandom, $urandom}, {$urandom, $urandom});
				quota--;
			end else if (roll < 98) begin
				send_request(CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)),
					{$urandom, $urandom}, {$urandom, $urandom});
			end else begin
				send_request(CMD_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
				quota--;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_request(CMD_LOOKUP, 64'd5, '0);
		send_request(CMD_ITER_FIRST, '0, '0);
		send_request(CMD_ITER_NEXT, '0, '0);
		send_request(CMD_INSERT, '0, 64'd123);
		send_request(CMD_INSERT, 64'd77, 64'd77);
		send_request(CMD_INSERT, ALL_ONES, '0);
		send_request(CMD_INSERT, TOP_BIT, ALL_ONES);
		send_request(CMD_INSERT, HASH_IN_MAX, 64'd1);
		send_request(CMD_INSERT, HASH_IN_ZERO, 64'd2);
		send_request(CMD_INSERT, ALL_ONES, 64'd9);
		send_request(CMD_LOOKUP, ALL_ONES, '0);
		send_request(CMD_LOOKUP, HASH_IN_MAX, '0);
		send_request(CMD_LOOKUP, '0, '0);
		send_request(CMD_LOOKUP, HASH_IN_ALIAS, '0);
		send_request(CMD_ITER_FIRST, '0, '0);
		repeat (4) send_request(CMD_ITER_NEXT, '0, '0);
		send_request(CMD_ITER_NEXT, ALL_ONES, ALL_ONES);
		send_request(CMD_ITER_FIRST, '0, '0);
		send_request(CMD_ITER_FIRST, '0, '0);
		send_request(CMD_RSVD_FIRST, ALL_ONES, ALL_ONES);
		send_request(CMD_RSVD_LAST, '0, '0);
		send_request(CMD_CLEAR, '0, '0);

		foreach (phase_slots[p]) begin
			hold_and_set_slots(CFG_W'(phase_slots[p]));
			if ($urandom_range(0, 1) == 0)
				send_request(CMD_CLEAR, '0, '0);
			run_mix((phase_slots[p] >= 256) ? BIG_QUOTA : SMALL_QUOTA);
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[old_new_hash_map.f]
+incdir+hdl
hdl/ohm_pkg.sv
hdl/ohm_ram.sv
hdl/ohm_hash.sv
hdl/old_new_hash_map.sv
hdl/ohm_checker.sv
tb/old_new_hash_map_checker.sv
tb/old_new_hash_map_tb.sv
